// ----- src/matrix_multiply_defines.svh -----
// ----------------------------------------------------------------------------
// matrix_multiply_defines.svh
// Assertion macros for the matrix multiplier checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mm_pkg.sv -----
// ----------------------------------------------------------------------------
// mm_pkg
// Types, constants and helpers for the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DIM_W       = 4;   // dimension register width
  localparam int IDX_W       = 3;   // row / column index width
  localparam int ELEM_W      = 16;  // Q8.8 element
  localparam int PROD_W      = 32;  // Q16.16 product
  localparam int VAL_W       = 40;  // Q24.16 accumulated value
  localparam int ADDR_FULL_W = 6;   // row * dim + col before trimming
  localparam int CFG_IDX_W   = 2;

  localparam logic [DIM_W-1:0] CFG_RESET = DIM_W'(8);

  // Opcodes
  localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLS = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } mm_state_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element;
  } mm_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    size_error;
    logic                    last;
  } mm_out_t;

  // Per-step tag that travels with a store read down the datapath
  typedef struct packed {
    logic             valid;
    logic             first;     // first term of a dot product
    logic             last;      // last term, result is complete
    logic             final_el;  // last element of the run
    logic             err;       // size mismatch echo
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mm_tag_t;

  // Dimension clamp: zero acts as one, above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                               input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] res;
    res = r;
    if (r == '0) begin
      res = DIM_W'(1);
    end else if (r > max_v) begin
      res = max_v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/mm_ram.sv -----
// ----------------------------------------------------------------------------
// mm_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and write of one entry in the same cycle sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/mm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mm_ctrl
// Configuration registers, load decode and the i/j/k read sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mm_ctrl import mm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire mm_in_t                in_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DIM_W-1:0]      cfg_data,
  input  wire logic                  adv,
  output logic                       lwe,
  output logic                       rwe,
  output logic [AW-1:0]              waddr,
  output logic [ELEM_W-1:0]          wdata,
  output logic [AW-1:0]              laddr,
  output logic [AW-1:0]              raddr,
  output mm_tag_t                    tag
);

  localparam logic [DIM_W-1:0] MAX_V = DIM_W'(MAX_DIM);

  mm_state_t        state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0] rows_r, rows_nxt, cols_r, cols_nxt, klim_r, klim_nxt;
  logic             err_r, err_nxt;
  logic [DIM_W-1:0] lrows_r, lcols_r, rrows_r, rcols_r;
  logic [DIM_W-1:0] lr, lc, rr, rc;
  logic             step_last, row_end, col_end, in_range;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    logic [ADDR_FULL_W-1:0] full;
    full = ADDR_FULL_W'(r) * ADDR_FULL_W'(MAX_DIM) + ADDR_FULL_W'(c);
    return full[AW-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrows_r <= CFG_RESET;
      lcols_r <= CFG_RESET;
      rrows_r <= CFG_RESET;
      rcols_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEFT_ROWS:  lrows_r <= cfg_data;
        CFG_LEFT_COLS:  lcols_r <= cfg_data;
        CFG_RIGHT_ROWS: rrows_r <= cfg_data;
        CFG_RIGHT_COLS: rcols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      rows_r  <= DIM_W'(1);
      cols_r  <= DIM_W'(1);
      klim_r  <= DIM_W'(1);
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      rows_r  <= rows_nxt;
      cols_r  <= cols_nxt;
      klim_r  <= klim_nxt;
      err_r   <= err_nxt;
    end
  end

  assign lr = eff_dim(lrows_r, MAX_V);
  assign lc = eff_dim(lcols_r, MAX_V);
  assign rr = eff_dim(rrows_r, MAX_V);
  assign rc = eff_dim(rcols_r, MAX_V);

  assign step_last = ({1'b0, k_r} == klim_r - DIM_W'(1));
  assign row_end   = ({1'b0, i_r} == rows_r - DIM_W'(1));
  assign col_end   = ({1'b0, j_r} == cols_r - DIM_W'(1));
  assign in_range  = ({1'b0, in_data.row_index} < MAX_V) &&
                     ({1'b0, in_data.col_index} < MAX_V);

  // Store write port: loads are taken only while idle
  assign waddr = addr_of(in_data.row_index, in_data.col_index);
  assign wdata = in_data.element;

  // Read addresses: echo reads right[i][j], product reads left[i][k], right[k][j]
  assign laddr = addr_of(i_r, k_r);
  assign raddr = err_r ? addr_of(i_r, j_r) : addr_of(k_r, j_r);

  // Next state and issue
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    klim_nxt  = klim_r;
    err_nxt   = err_r;
    in_ready  = 1'b0;
    lwe       = 1'b0;
    rwe       = 1'b0;
    tag       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_data.opcode)
            OP_LOAD_LEFT:  lwe = in_range;
            OP_LOAD_RIGHT: rwe = in_range;
            OP_COMPUTE: begin
              err_nxt   = (lc != rr);
              rows_nxt  = (lc != rr) ? rr : lr;
              cols_nxt  = rc;
              klim_nxt  = (lc != rr) ? DIM_W'(1) : lc;
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        tag.valid    = 1'b1;
        tag.first    = (k_r == '0);
        tag.last     = step_last;
        tag.final_el = step_last && row_end && col_end;
        tag.err      = err_r;
        tag.row      = i_r;
        tag.col      = j_r;
        if (adv) begin
          if (!step_last) begin
            k_nxt = k_r + IDX_W'(1);
          end else begin
            k_nxt = '0;
            if (!col_end) begin
              j_nxt = j_r + IDX_W'(1);
            end else begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
              if (row_end) begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/mm_mac.sv -----
// ----------------------------------------------------------------------------
// mm_mac
// Multiply, accumulate and output register; stalls the pipe on backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mm_mac import mm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mm_tag_t           tag,
  input  wire logic [ELEM_W-1:0] ldata,
  input  wire logic [ELEM_W-1:0] rdata,
  output logic                   adv,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mm_out_t                out_data
);

  mm_tag_t                  s1_tag_r, s2_tag_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [VAL_W-1:0]  acc_r, sum;
  logic                     out_valid_r, out_valid_nxt;
  mm_out_t                  out_data_r;

  // Hold the whole pipe when a finished dot product cannot enter the output
  assign adv = !(s2_tag_r.valid && s2_tag_r.last && out_valid_r && !out_ready);

  // Product or echo of the right element shifted into Q16.16
  always_comb begin
    if (s1_tag_r.err) begin
      prod_nxt = {{(PROD_W-ELEM_W-8){rdata[ELEM_W-1]}}, rdata, 8'h00};
    end else begin
      prod_nxt = $signed(ldata) * $signed(rdata);
    end
  end

  assign sum = (s2_tag_r.first ? '0 : acc_r) + VAL_W'(prod_r);

  // Output valid: set by a finished element, cleared when the transaction is taken
  assign out_valid_nxt = (adv && s2_tag_r.valid && s2_tag_r.last) ? 1'b1 :
                         (out_valid_r && !out_ready);

  // Control: tag pipe and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r    <= '0;
      s2_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        s1_tag_r <= tag;
        s2_tag_r <= s1_tag_r;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      if (s2_tag_r.valid) begin
        if (s2_tag_r.last) begin
          out_data_r.out_row    <= s2_tag_r.row;
          out_data_r.out_col    <= s2_tag_r.col;
          out_data_r.out_value  <= sum;
          out_data_r.size_error <= s2_tag_r.err;
          out_data_r.last       <= s2_tag_r.final_el;
        end else begin
          acc_r <= sum;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- src/matrix_multiply.sv -----
// Load transaction: one accepted per cycle while idle.
// Compute transaction: rows*cols*left_cols store read steps (rows*cols on a size mismatch),
//   one per cycle unless the output stalls, through the store read, product and output registers.
// Input is taken again right after the last read step; the read port of each
//   store, one access per cycle, sets the rate. Output backpressure stalls it.
// Reset (rst_n low, synchronous): control idle, dimensions 8; stores kept.
// ----------------------------------------------------------------------------
// matrix_multiply
// Fixed-point matrix multiplier over two element stores, Q8.8 in, Q24.16 out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire mm_in_t               in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mm_out_t                   out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  logic              adv, lwe, rwe;
  logic [AW-1:0]     waddr, laddr, raddr;
  logic [ELEM_W-1:0] wdata, ldata, rdata;
  mm_tag_t           tag;

  // Sequencer and configuration
  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (adv),
    .lwe       (lwe),
    .rwe       (rwe),
    .waddr     (waddr),
    .wdata     (wdata),
    .laddr     (laddr),
    .raddr     (raddr),
    .tag       (tag)
  );

  // Left matrix store
  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (lwe),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (laddr),
    .rdata (ldata)
  );

  // Right matrix store
  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (rwe),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Multiply-accumulate and output register
  mm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag),
    .ldata     (ldata),
    .rdata     (rdata),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- src/mm_chk.sv -----
// ----------------------------------------------------------------------------
// mm_chk
// Port-level checks for the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_multiply_defines.svh"

module mm_chk import mm_pkg::*; (
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire mm_in_t  in_data,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire mm_out_t out_data
);

  // A stalled result transaction holds
  `MM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // The input side closes only after a compute transaction
  `MM_ASSERT_IMPL(a_ready_drop, $fell(in_ready), $past(in_valid) && ($past(in_data.opcode) == OP_COMPUTE), "input closed without a compute")

  // Echoed elements are Q8.8 shifted into Q24.16
  `MM_ASSERT_IMPL(a_echo_shift, out_valid && out_data.size_error, out_data.out_value[7:0] == 8'h00, "echoed value not shifted")

endmodule

bind matrix_multiply mm_chk u_mm_chk (.*);

`default_nettype wire

// ----- verif/matrix_multiply_tb.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_tb
// Self-checking bench for the fixed-point matrix multiplier. It loads both
// element stores, programs the four dimension registers and issues compute
// transactions. A scoreboard predicts every product element (or the echoed
// right matrix on a size mismatch) and checks each result transaction in order.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_multiply_tb import mm_pkg::*;;

  localparam int DIM           = MAX_DIM_DEF;
  localparam int N_ITEMS       = 300;
  localparam int SETTLE_CYCLES = DIM + 8;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  mm_in_t               in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  mm_out_t              out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  // Shadow copy of the stores and dimension registers
  logic signed [ELEM_W-1:0] left_mem    [DIM*DIM];
  logic signed [ELEM_W-1:0] right_mem   [DIM*DIM];
  bit                       left_loaded [DIM*DIM];
  bit                       right_loaded[DIM*DIM];
  logic [DIM_W-1:0]         dim_reg     [4] = '{default: CFG_RESET};

  mm_out_t pending_elems[$];
  int      mismatch_cnt = 0;
  int      item_count   = 0;
  int      quiet_cycles = 0;
  bit      burst_mode   = 1'b0;
  bit      extreme_fill = 1'b0;

  always #5 clk = ~clk;

  matrix_multiply u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Random draws
  // ---------------------------------------------------------------------------
  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic signed [ELEM_W-1:0] draw_element();
    int roll;
    roll = $urandom_range(0, 15);
    if (extreme_fill) begin
      return roll[0] ? ELEM_MIN : ELEM_MAX;
    end
    case (roll)
      0, 1:    return ELEM_MIN;
      2, 3:    return ELEM_MAX;
      4:       return '0;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Mostly small sizes; sometimes full size or an out-of-range setting
  function automatic logic [DIM_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll <= 5) begin
      return DIM_W'($urandom_range(1, 3));
    end else if (roll <= 7) begin
      return DIM_W'($urandom_range(4, DIM));
    end else if (roll == 8) begin
      return DIM_W'(DIM);
    end
    return $urandom_range(0, 1) ? '0 : DIM_W'($urandom_range(DIM + 1, 15));
  endfunction

  // Zero acts as one, anything past the store size acts as the store size
  function automatic int clamp_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    return (int'(raw) > DIM) ? DIM : int'(raw);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: updates the shadow stores, queues the expected result elements
  // ---------------------------------------------------------------------------
  function automatic void predict_product(input mm_in_t t);
    int lr, lc, rr, rc, n_rows, addr;
    bit echo;
    logic signed [VAL_W-1:0] acc;
    mm_out_t elem;
    addr = int'(t.row_index) * DIM + int'(t.col_index);
    case (t.opcode)
      OP_LOAD_LEFT: begin
        left_mem[addr]    = t.element;
        left_loaded[addr] = 1'b1;
      end
      OP_LOAD_RIGHT: begin
        right_mem[addr]    = t.element;
        right_loaded[addr] = 1'b1;
      end
      OP_COMPUTE: begin
        lr     = clamp_dim(dim_reg[CFG_LEFT_ROWS]);
        lc     = clamp_dim(dim_reg[CFG_LEFT_COLS]);
        rr     = clamp_dim(dim_reg[CFG_RIGHT_ROWS]);
        rc     = clamp_dim(dim_reg[CFG_RIGHT_COLS]);
        echo   = (lc != rr);
        n_rows = echo ? rr : lr;
        for (int i = 0; i < n_rows; i++) begin
          for (int j = 0; j < rc; j++) begin
            if (echo) begin
              // right element widened to Q24.16
              acc = right_mem[i*DIM + j];
              acc = acc <<< 8;
            end else begin
              acc = '0;
              for (int k = 0; k < lc; k++) begin
                acc = acc + left_mem[i*DIM + k] * right_mem[k*DIM + j];
              end
            end
            elem.out_row    = IDX_W'(i);
            elem.out_col    = IDX_W'(j);
            elem.out_value  = acc;
            elem.size_error = echo;
            elem.last       = (i == n_rows - 1) && (j == rc - 1);
            pending_elems.insert(pending_elems.size(), elem);
          end
        end
      end
      default: ;  // unused opcode: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel
  // ---------------------------------------------------------------------------
  task automatic send_txn(input mm_in_t t);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_product(t);
    if (t.opcode != OP_UNUSED) begin
      item_count++;
    end
  endtask

  task automatic load_elem(input logic [1:0] op, input int row, input int col,
                           input logic signed [ELEM_W-1:0] value);
    mm_in_t t;
    t.opcode    = op;
    t.row_index = IDX_W'(row);
    t.col_index = IDX_W'(col);
    t.element   = value;
    send_txn(t);
  endtask

  // Compute ignores the other fields; fill them with noise anyway
  task automatic run_compute();
    load_elem(OP_COMPUTE, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
              ELEM_W'($urandom));
  endtask

  task automatic send_noise();
    load_elem(OP_UNUSED, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
              ELEM_W'($urandom));
  endtask

  // Load every store entry the next compute reads that has never been written
  task automatic fill_gaps();
    int lr, lc, rr, rc;
    lr = clamp_dim(dim_reg[CFG_LEFT_ROWS]);
    lc = clamp_dim(dim_reg[CFG_LEFT_COLS]);
    rr = clamp_dim(dim_reg[CFG_RIGHT_ROWS]);
    rc = clamp_dim(dim_reg[CFG_RIGHT_COLS]);
    if (lc == rr) begin
      for (int i = 0; i < lr; i++) begin
        for (int k = 0; k < lc; k++) begin
          if (!left_loaded[i*DIM + k]) begin
            load_elem(OP_LOAD_LEFT, i, k, draw_element());
          end
        end
      end
    end
    for (int i = 0; i < rr; i++) begin
      for (int j = 0; j < rc; j++) begin
        if (!right_loaded[i*DIM + j]) begin
          load_elem(OP_LOAD_RIGHT, i, j, draw_element());
        end
      end
    end
  endtask

  // Drop valid, let every expected element come back, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration channel (only used while the block is idle)
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [DIM_W-1:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dim_reg[idx] = value;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] lr, input logic [DIM_W-1:0] lc,
                          input logic [DIM_W-1:0] rr, input logic [DIM_W-1:0] rc);
    cfg_write(CFG_LEFT_ROWS, lr);
    cfg_write(CFG_LEFT_COLS, lc);
    cfg_write(CFG_RIGHT_ROWS, rr);
    cfg_write(CFG_RIGHT_COLS, rc);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // 1x1 products at the corners of the element range
  task automatic test_single_element();
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    load_elem(OP_LOAD_LEFT, 0, 0, ELEM_MIN);
    load_elem(OP_LOAD_RIGHT, 0, 0, ELEM_MIN);
    run_compute();
    load_elem(OP_LOAD_LEFT, 0, 0, ELEM_MAX);
    run_compute();
    load_elem(OP_LOAD_RIGHT, 0, 0, ELEM_MAX);
    run_compute();
    wait_idle();
  endtask

  // Left columns differ from right rows: right matrix comes back flagged
  task automatic test_size_mismatch();
    set_dims(4'd2, 4'd3, 4'd2, 4'd3);
    load_elem(OP_LOAD_RIGHT, 1, 2, ELEM_MIN);
    load_elem(OP_LOAD_RIGHT, 0, 1, ELEM_MAX);
    fill_gaps();
    run_compute();
    wait_idle();
  endtask

  // Zero and oversize register values clamp, for sizing and for the size check
  task automatic test_dim_clamp();
    set_dims(4'd0, 4'd0, 4'd0, 4'd15);
    fill_gaps();
    run_compute();
    wait_idle();
    set_dims(4'd0, 4'd9, 4'd0, 4'd0);
    run_compute();
    wait_idle();
  endtask

  // Unused opcode must leave the stores alone and emit nothing
  task automatic test_ignored_opcode();
    load_elem(OP_UNUSED, 0, 0, ELEM_MAX);
    send_noise();
    run_compute();
    wait_idle();
  endtask

  // Random phases: new sizes, random loads with some noise, then computes
  task automatic test_random_traffic();
    logic [DIM_W-1:0] lr, lc, rr, rc;
    logic [1:0] op;
    int n_runs, n_loads, roll, row_lim, col_lim;
    bit first_phase;
    first_phase = 1'b1;
    while (item_count < N_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if (first_phase) begin
        // full size with extreme elements everywhere not yet written
        lr = DIM_W'(DIM);
        lc = DIM_W'(DIM);
        rr = DIM_W'(DIM);
        rc = DIM_W'(DIM);
      end else begin
        lr = pick_dim();
        lc = pick_dim();
        rr = ($urandom_range(0, 3) != 0) ? lc : pick_dim();
        rc = pick_dim();
      end
      set_dims(lr, lc, rr, rc);
      extreme_fill = first_phase;
      n_runs = $urandom_range(1, 3);
      repeat (n_runs) begin
        n_loads = $urandom_range(0, 10);
        repeat (n_loads) begin
          roll = $urandom_range(0, 9);
          if (roll == 0) begin
            send_noise();
          end else begin
            op      = $urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT;
            row_lim = clamp_dim((op == OP_LOAD_LEFT) ? lr : rr);
            col_lim = clamp_dim((op == OP_LOAD_LEFT) ? lc : rc);
            if (roll <= 2) begin
              row_lim = DIM;
              col_lim = DIM;
            end
            load_elem(op, $urandom_range(0, row_lim - 1), $urandom_range(0, col_lim - 1),
                      draw_element());
          end
        end
        fill_gaps();
        run_compute();
      end
      extreme_fill = 1'b0;
      first_phase  = 1'b0;
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker with random output stalls
  // ---------------------------------------------------------------------------
  task automatic field_mismatch(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatch_cnt++;
  endtask

  initial begin : result_monitor
    mm_out_t want;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_elems.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual row %0d col %0d value %0d",
                   $time, out_data.out_row, out_data.out_col, out_data.out_value);
          mismatch_cnt++;
        end else begin
          want = pending_elems.pop_front();
          if (out_data.out_row !== want.out_row)
            field_mismatch("out_row", want.out_row, out_data.out_row);
          if (out_data.out_col !== want.out_col)
            field_mismatch("out_col", want.out_col, out_data.out_col);
          if (out_data.out_value !== want.out_value)
            field_mismatch("out_value", want.out_value, out_data.out_value);
          if (out_data.size_error !== want.size_error)
            field_mismatch("size_error", want.size_error, out_data.size_error);
          if (out_data.last !== want.last)
            field_mismatch("last", want.last, out_data.last);
        end
        stall = draw_gap();
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction on any channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("matrix_multiply_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_single_element();
    test_size_mismatch();
    test_dim_clamp();
    test_ignored_opcode();
    test_random_traffic();
    if (mismatch_cnt == 0) begin
      $display("matrix_multiply_tb: PASS");
    end else begin
      $display("matrix_multiply_tb: FAIL");
    end
    $finish;
  end

endmodule
